FILE: design/lbmd_pkg.sv
// ---------------------------------------------------------------------------
// lbmd_pkg
// Types, widths and constant tables of the lidar beam deskew pipeline.
// ---------------------------------------------------------------------------
package lbmd_pkg;

	localparam int MAX_SEGMENT_BEAMS = 1024;
	localparam int CNT_W      = 11;
	localparam int OFF_W      = 10;
	localparam int DEN_W      = 11;
	localparam int DIV_W      = 12;
	localparam int NUM_W      = 38;
	localparam int QUO_W      = 26;
	localparam int DIV_STAGES = QUO_W / 2;
	localparam int CORDIC_STEPS = 18;
	localparam int FRAC_BITS  = 12;
	localparam int RW         = 31;
	localparam int PW         = 42;
	localparam int ZW         = 26;
	localparam int NSTG       = 59;

	localparam logic [23:0] GAIN_INV    = 24'd10188014;
	localparam logic [ZW-1:0] HALF_TURN_Z = ZW'(8388608);

	typedef enum logic [1:0] {
		REG_BASE_X   = 2'd0,
		REG_BASE_Y   = 2'd1,
		REG_BASE_YAW = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] range;
		logic [15:0] angle;
		logic        rv;
		logic [23:0] sx;
		logic [23:0] sy;
		logic [15:0] syaw;
	} side_t;

	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [QUO_W-1:0] quo;
		logic [QUO_W-1:0] low;
	} div_lane_t;

	typedef struct packed {
		side_t            s;
		logic [2:0]       neg;
		logic [DIV_W-1:0] d;
	} dside_t;

	typedef struct packed {
		logic [RW-1:0] x;
		logic [RW-1:0] y;
		logic [ZW-1:0] z;
	} rot_t;

	typedef struct packed {
		logic [PW-1:0] x;
		logic [PW-1:0] y;
		logic [ZW-1:0] z;
	} pol_t;

	typedef struct packed {
		logic        rv;
		logic [15:0] inv_ang;
		logic [PW-1:0] offx;
		logic [PW-1:0] offy;
	} rside_t;

	typedef struct packed {
		logic        rv;
		logic [15:0] inv_ang;
	} pside_t;

	function automatic logic signed [ZW-1:0] atan_unit(input int k);
		logic signed [ZW-1:0] v;
		case (k)
			0:  v = ZW'(2097152);
			1:  v = ZW'(1238021);
			2:  v = ZW'(654136);
			3:  v = ZW'(332050);
			4:  v = ZW'(166669);
			5:  v = ZW'(83416);
			6:  v = ZW'(41718);
			7:  v = ZW'(20860);
			8:  v = ZW'(10430);
			9:  v = ZW'(5215);
			10: v = ZW'(2608);
			11: v = ZW'(1304);
			12: v = ZW'(652);
			13: v = ZW'(326);
			14: v = ZW'(163);
			15: v = ZW'(81);
			16: v = ZW'(41);
			17: v = ZW'(20);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: design/lidar_beam_motion_deskew.sv
// ---------------------------------------------------------------------------
// lidar_beam_motion_deskew
// Interpolates a beam's pose inside its segment and re-expresses the beam
// in polar form relative to the configured base pose.
// ---------------------------------------------------------------------------
// One beam enters per clock while the output is not stalled; the pipeline
// holds as a whole while a finished result is stalled at the output. The
// depth is set by a two-bit-per-stage divider for the pose interpolation
// (13 stages), two 18-step CORDIC chains of one step per stage, and the
// split gain multiplications. Base pose registers are to be written through
// the cfg port only while no beam is in flight; the block does not check.
module lidar_beam_motion_deskew (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] beam_range,
	input  logic signed [15:0] beam_angle,
	input  logic        range_valid,
	input  logic signed [23:0] seg_start_x,
	input  logic signed [23:0] seg_start_y,
	input  logic signed [15:0] seg_start_yaw,
	input  logic signed [23:0] seg_end_x,
	input  logic signed [23:0] seg_end_y,
	input  logic signed [15:0] seg_end_yaw,
	input  logic [lbmd_pkg::OFF_W-1:0] beam_offset,
	input  logic [lbmd_pkg::CNT_W-1:0] segment_beams,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_wdata,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [23:0] corrected_range,
	output logic signed [15:0] corrected_angle,
	output logic        out_valid
);
	import lbmd_pkg::*;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENT_BEAMS);

	logic adv;
	logic [NSTG-1:0] vld_q;
	logic signed [23:0] base_x_q, base_y_q;
	logic signed [15:0] base_yaw_q;

	assign adv      = !res_stall || !vld_q[NSTG-1];
	assign in_stall = !adv;
	assign res_valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTG-2:0], in_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_x_q   <= '0;
			base_y_q   <= '0;
			base_yaw_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BASE_X:   base_x_q   <= cfg_wdata;
				REG_BASE_Y:   base_y_q   <= cfg_wdata;
				REG_BASE_YAW: base_yaw_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// ---------------- stage 1: clamp counts, form differences
	logic [CNT_W-1:0] cnt_c;
	logic [DEN_W-1:0] den_c;
	logic [OFF_W-1:0] off_c;
	logic signed [15:0] dyaw16;

	always_comb begin
		cnt_c = (segment_beams > MAX_CNT) ? MAX_CNT : segment_beams;
		if (cnt_c <= CNT_W'(1)) begin
			den_c = DEN_W'(1);
			off_c = '0;
		end else begin
			den_c = DEN_W'(cnt_c - CNT_W'(1));
			off_c = (DEN_W'(beam_offset) > den_c) ? den_c[OFF_W-1:0] : beam_offset;
		end
		dyaw16 = seg_end_yaw - seg_start_yaw;
	end

	side_t side_s1, side_s2;
	logic [DEN_W-1:0] den_s1, den_s2;
	logic [OFF_W-1:0] off_s1;
	logic signed [24:0] dx_s1, dy_s1, dyaw_s1;
	logic signed [35:0] px_s2, py_s2, pyaw_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= '{range: beam_range, angle: beam_angle, rv: range_valid,
				sx: seg_start_x, sy: seg_start_y, syaw: seg_start_yaw};
			den_s1  <= den_c;
			off_s1  <= off_c;
			dx_s1   <= $signed({seg_end_x[23], seg_end_x}) - $signed({seg_start_x[23], seg_start_x});
			dy_s1   <= $signed({seg_end_y[23], seg_end_y}) - $signed({seg_start_y[23], seg_start_y});
			dyaw_s1 <= 25'(dyaw16);
		end
	end

	// ---------------- stage 2: difference times offset
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_s1;
			den_s2  <= den_s1;
			px_s2   <= dx_s1 * $signed({1'b0, off_s1});
			py_s2   <= dy_s1 * $signed({1'b0, off_s1});
			pyaw_s2 <= dyaw_s1 * $signed({1'b0, off_s1});
		end
	end

	// ---------------- stage 3: signed numerator to magnitude for the divider
	function automatic div_lane_t div_load(input logic signed [35:0] p,
		input logic [DEN_W-1:0] den, output logic neg);
		logic signed [NUM_W-1:0] n;
		logic [NUM_W-1:0] u;
		div_lane_t l;
		n = $signed({p[35], p, 1'b0}) + $signed({(NUM_W - DEN_W)'(0), den});
		neg = n[NUM_W-1];
		// floor of a negative quotient: negate the ceiling of the magnitude
		if (neg)
			u = NUM_W'(-n) + NUM_W'({den, 1'b0}) - NUM_W'(1);
		else
			u = n;
		l.rem = u[NUM_W-1:QUO_W];
		l.low = u[QUO_W-1:0];
		l.quo = '0;
		return l;
	endfunction

	function automatic div_lane_t div_step(input div_lane_t a, input logic [DIV_W-1:0] d);
		div_lane_t b;
		logic [DIV_W:0] t;
		b = a;
		for (int i = 0; i < 2; i++) begin
			t = {b.rem, b.low[QUO_W-1]};
			b.low = {b.low[QUO_W-2:0], 1'b0};
			if (t >= {1'b0, d}) begin
				b.rem = DIV_W'(t - {1'b0, d});
				b.quo = {b.quo[QUO_W-2:0], 1'b1};
			end else begin
				b.rem = t[DIV_W-1:0];
				b.quo = {b.quo[QUO_W-2:0], 1'b0};
			end
		end
		return b;
	endfunction

	div_lane_t div_s [0:DIV_STAGES][3];
	dside_t    ds_s  [0:DIV_STAGES];

	always_ff @(posedge clk) begin
		logic nx, ny, nyaw;
		if (adv) begin
			div_s[0][0] <= div_load(px_s2, den_s2, nx);
			div_s[0][1] <= div_load(py_s2, den_s2, ny);
			div_s[0][2] <= div_load(pyaw_s2, den_s2, nyaw);
			ds_s[0] <= '{s: side_s2, neg: {nyaw, ny, nx}, d: {den_s2, 1'b0}};
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int j = 0; j < 3; j++)
					div_s[k+1][j] <= div_step(div_s[k][j], ds_s[k].d);
				ds_s[k+1] <= ds_s[k];
			end
		end
	end

	// ---------------- mid pose, rotation setup
	function automatic logic signed [QUO_W:0] quo_signed(input div_lane_t l, input logic neg);
		logic signed [QUO_W:0] q;
		q = $signed({1'b0, l.quo});
		return neg ? -q : q;
	endfunction

	rot_t   rot_s [0:CORDIC_STEPS];
	rside_t rs_s  [0:CORDIC_STEPS];

	always_comb begin
	end

	always_ff @(posedge clk) begin
		logic signed [QUO_W:0] qx, qy, qyaw;
		logic signed [QUO_W+1:0] mx, my;
		logic signed [QUO_W+2:0] relx, rely;
		logic signed [15:0] myaw, phi;
		logic signed [16:0] zf;
		logic signed [RW-1:0] x0;
		side_t s;
		if (adv) begin
			s    = ds_s[DIV_STAGES].s;
			qx   = quo_signed(div_s[DIV_STAGES][0], ds_s[DIV_STAGES].neg[0]);
			qy   = quo_signed(div_s[DIV_STAGES][1], ds_s[DIV_STAGES].neg[1]);
			qyaw = quo_signed(div_s[DIV_STAGES][2], ds_s[DIV_STAGES].neg[2]);
			mx   = (QUO_W+2)'($signed(s.sx)) + (QUO_W+2)'(qx);
			my   = (QUO_W+2)'($signed(s.sy)) + (QUO_W+2)'(qy);
			relx = (QUO_W+3)'(mx) - (QUO_W+3)'(base_x_q);
			rely = (QUO_W+3)'(my) - (QUO_W+3)'(base_y_q);
			myaw = $signed(s.syaw) + qyaw[15:0];
			phi  = $signed(s.angle) + myaw;
			x0   = $signed({(RW - 16 - FRAC_BITS)'(0), s.range, FRAC_BITS'(0)});
			// fold the angle into the right half plane
			if (phi > 16'sd16384) begin
				x0 = -x0;
				zf = $signed({phi[15], phi}) - 17'sd32768;
			end else if (phi < -16'sd16384) begin
				x0 = -x0;
				zf = $signed({phi[15], phi}) + 17'sd32768;
			end else begin
				zf = $signed({phi[15], phi});
			end
			rot_s[0] <= '{x: x0, y: '0, z: ZW'($signed({zf, 8'b0}))};
			rs_s[0]  <= '{rv: s.rv, inv_ang: s.angle + qyaw[15:0],
				offx: PW'($signed({relx, FRAC_BITS'(0)})),
				offy: PW'($signed({rely, FRAC_BITS'(0)}))};
		end
	end

	// ---------------- rotation CORDIC
	function automatic rot_t rot_step(input rot_t a, input int k);
		rot_t b;
		logic signed [RW-1:0] xs, ys;
		xs = $signed(a.x) >>> k;
		ys = $signed(a.y) >>> k;
		if (!a.z[ZW-1]) begin
			b.x = $signed(a.x) - ys;
			b.y = $signed(a.y) + xs;
			b.z = $signed(a.z) - atan_unit(k);
		end else begin
			b.x = $signed(a.x) + ys;
			b.y = $signed(a.y) - xs;
			b.z = $signed(a.z) + atan_unit(k);
		end
		return b;
	endfunction

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
		always_ff @(posedge clk) begin
			if (adv) begin
				rot_s[k+1] <= rot_step(rot_s[k], k);
				rs_s[k+1]  <= rs_s[k];
			end
		end
	end

	// ---------------- gain compensation and offset to base
	logic signed [RW+24:0] gx_g, gy_g;
	rside_t rs_g;
	logic signed [PW-1:0] sx_r1, sy_r1;
	pside_t ps_r1;

	always_ff @(posedge clk) begin
		if (adv) begin
			gx_g <= $signed(rot_s[CORDIC_STEPS].x) * $signed({1'b0, GAIN_INV});
			gy_g <= $signed(rot_s[CORDIC_STEPS].y) * $signed({1'b0, GAIN_INV});
			rs_g <= rs_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		logic signed [RW+24:0] cx, cy;
		if (adv) begin
			cx = (gx_g + (RW+25)'(1 << 23)) >>> 24;
			cy = (gy_g + (RW+25)'(1 << 23)) >>> 24;
			sx_r1 <= PW'(cx) + $signed(rs_g.offx);
			sy_r1 <= PW'(cy) + $signed(rs_g.offy);
			ps_r1 <= '{rv: rs_g.rv, inv_ang: rs_g.inv_ang};
		end
	end

	// ---------------- vectoring CORDIC
	pol_t   pol_s [0:CORDIC_STEPS];
	pside_t ps_s  [0:CORDIC_STEPS];

	always_ff @(posedge clk) begin
		if (adv) begin
			if (sx_r1 < 0)
				pol_s[0] <= '{x: -sx_r1, y: -sy_r1, z: HALF_TURN_Z};
			else
				pol_s[0] <= '{x: sx_r1, y: sy_r1, z: '0};
			ps_s[0] <= ps_r1;
		end
	end

	function automatic pol_t pol_step(input pol_t a, input int k);
		pol_t b;
		logic signed [PW-1:0] xs, ys;
		xs = $signed(a.x) >>> k;
		ys = $signed(a.y) >>> k;
		if ($signed(a.y) > 0) begin
			b.x = $signed(a.x) + ys;
			b.y = $signed(a.y) - xs;
			b.z = $signed(a.z) + atan_unit(k);
		end else begin
			b.x = $signed(a.x) - ys;
			b.y = $signed(a.y) + xs;
			b.z = $signed(a.z) - atan_unit(k);
		end
		return b;
	endfunction

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_pol
		always_ff @(posedge clk) begin
			if (adv) begin
				pol_s[k+1] <= pol_step(pol_s[k], k);
				ps_s[k+1]  <= ps_s[k];
			end
		end
	end

	// ---------------- magnitude gain in two partial products, then output
	localparam int HB = PW / 2;
	logic [HB+23:0] pl_p1, ph_p2, pl_p2;
	logic [PW-HB-1:0] hi_p1;
	logic [ZW-1:0] z_p1, z_p2;
	pside_t ps_p1, ps_p2;

	always_ff @(posedge clk) begin
		if (adv) begin
			pl_p1 <= (HB+24)'(pol_s[CORDIC_STEPS].x[HB-1:0] * GAIN_INV);
			hi_p1 <= pol_s[CORDIC_STEPS].x[PW-1:HB];
			z_p1  <= pol_s[CORDIC_STEPS].z;
			ps_p1 <= ps_s[CORDIC_STEPS];
			ph_p2 <= (HB+24)'(hi_p1 * GAIN_INV);
			pl_p2 <= pl_p1;
			z_p2  <= z_p1;
			ps_p2 <= ps_p1;
		end
	end

	always_ff @(posedge clk) begin
		logic [PW+24:0] sum;
		logic [PW+24-36:0] mag;
		logic [ZW-1:0] zr;
		if (adv) begin
			sum = {(PW+25-HB-24-HB)'(0), ph_p2, HB'(0)} + (PW+25)'(pl_p2)
				+ (PW+25)'(64'd1 << 35);
			mag = sum[PW+24:36];
			zr  = z_p2 + ZW'(128);
			out_valid <= ps_p2.rv;
			if (ps_p2.rv) begin
				corrected_range <= (mag > (PW+25-36)'(24'hFFFFFF)) ? 24'hFFFFFF : mag[23:0];
				corrected_angle <= $signed(zr[23:8]) - base_yaw_q;
			end else begin
				corrected_range <= '0;
				corrected_angle <= ps_p2.inv_ang;
			end
		end
	end

endmodule
